### rtl/core/dual_wheel_speed_pid_unit_macros.svh
// Assertion macros shared by the dual wheel speed PID RTL.
`ifndef DUAL_WHEEL_SPEED_PID_UNIT_MACROS_SVH
`define DUAL_WHEEL_SPEED_PID_UNIT_MACROS_SVH

// Check a consequence in the same cycle as its condition.
`define DWSP_ASSERT_NOW(name, clk_s, rst_s, ante, cons, msg) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its condition.
`define DWSP_ASSERT_NEXT(name, clk_s, rst_s, ante, cons, msg) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/dwsp_pkg.sv
package dwsp_pkg;

    // Field and register widths
    localparam int DATA_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int DUTY_W    = 7;
    localparam int ERR_W     = 24;
    localparam int INTEG_W   = 32;
    localparam int Q_FRAC_W  = 8;
    localparam int PCT_SHIFT = 16;

    // Slowdown datapath
    localparam int SLOW_PROD_W = 2 * DATA_W;
    localparam int SLOW_W      = SLOW_PROD_W - Q_FRAC_W;
    localparam int TGT_W       = SLOW_W + 2;

    // Lane datapath
    localparam int MUL_A_W = DATA_W + 1;
    localparam int MUL_B_W = INTEG_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = PROD_W;
    localparam int SCL_W   = ACC_W + DUTY_W;
    localparam int DIFF_W  = 2 * DATA_W + 3;
    localparam int WHOLE_W = SCL_W - PCT_SHIFT;

    localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

    localparam logic signed [ERR_W-1:0] ERR_MAX_V = {1'b0, {(ERR_W-1){1'b1}}};
    localparam logic signed [ERR_W-1:0] ERR_MIN_V = {1'b1, {(ERR_W-1){1'b0}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MAX_V = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN_V = {1'b1, {(INTEG_W-1){1'b0}}};

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_SETPOINT      = 3'd0,
        CFG_MIN_SPEED           = 3'd1,
        CFG_ANGLE_SLOWDOWN_GAIN = 3'd2,
        CFG_RATE_SLOWDOWN_GAIN  = 3'd3,
        CFG_SPEED_PER_COUNT     = 3'd4,
        CFG_PROP_GAIN           = 3'd5,
        CFG_INTEG_GAIN          = 3'd6,
        CFG_DERIV_GAIN          = 3'd7
    } cfg_idx_e;

    typedef struct packed {
        logic [DATA_W-1:0] speed_setpoint;
        logic [DATA_W-1:0] min_speed;
        logic [DATA_W-1:0] angle_slowdown_gain;
        logic [DATA_W-1:0] rate_slowdown_gain;
        logic [DATA_W-1:0] speed_per_count;
        logic [DATA_W-1:0] prop_gain;
        logic [DATA_W-1:0] integ_gain;
        logic [DATA_W-1:0] deriv_gain;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        speed_setpoint:      16'd1536,
        min_speed:           16'd384,
        angle_slowdown_gain: 16'd0,
        rate_slowdown_gain:  16'd0,
        speed_per_count:     16'd0,
        prop_gain:           16'd0,
        integ_gain:          16'd0,
        deriv_gain:          16'd0
    };

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              brake;
    } lane_res_t;

    typedef struct packed {
        logic      valid;
        lane_res_t res;
    } lane_stat_t;

endpackage

### rtl/core/dwsp_tick_if.sv
interface dwsp_tick_if;
    import dwsp_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] count_right;
    logic [DATA_W-1:0] count_left;
    logic [DATA_W-1:0] steer_angle_mag;
    logic [DATA_W-1:0] steer_rate_mag;

    modport source (
        output valid,
        output count_right,
        output count_left,
        output steer_angle_mag,
        output steer_rate_mag,
        input  ready
    );

    modport sink (
        input  valid,
        input  count_right,
        input  count_left,
        input  steer_angle_mag,
        input  steer_rate_mag,
        output ready
    );
endinterface

### rtl/core/dwsp_motor_if.sv
interface dwsp_motor_if;
    import dwsp_pkg::*;

    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] duty_right;
    logic              brake_right;
    logic [DUTY_W-1:0] duty_left;
    logic              brake_left;

    modport source (
        output valid,
        output duty_right,
        output brake_right,
        output duty_left,
        output brake_left,
        input  ready
    );

    modport sink (
        input  valid,
        input  duty_right,
        input  brake_right,
        input  duty_left,
        input  brake_left,
        output ready
    );
endinterface

### rtl/core/dwsp_slow.sv
module dwsp_slow (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dwsp_pkg::cfg_t                cfg,
    input  logic                          start,
    input  logic [dwsp_pkg::DATA_W-1:0]   angle,
    input  logic [dwsp_pkg::DATA_W-1:0]   rate,
    output logic                          target_valid,
    output logic [dwsp_pkg::DATA_W-1:0]   target
);
    import dwsp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ANG  = 4'b0010,
        S_RATE = 4'b0100,
        S_TGT  = 4'b1000
    } slow_state_e;

    slow_state_e              state_reg, state_next;
    logic [DATA_W-1:0]        angle_reg, rate_reg;
    logic [DATA_W-1:0]        op_gain, op_mag;
    logic [SLOW_PROD_W-1:0]   prod_reg;
    logic [SLOW_W-1:0]        slow_angle_reg;
    logic signed [TGT_W-1:0]  tgt_raw;
    logic [DATA_W-1:0]        target_next, target_reg;
    logic                     valid_reg;

    // Advance through the two products and the floor
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (start) state_next = S_ANG;
            S_ANG:  state_next = S_RATE;
            S_RATE: state_next = S_TGT;
            S_TGT:  state_next = S_IDLE;
        endcase
    end

    // Select the operands of the shared multiplier
    always_comb
    begin
        if (state_reg == S_ANG)
        begin
            op_gain = cfg.angle_slowdown_gain;
            op_mag  = angle_reg;
        end
        else
        begin
            op_gain = cfg.rate_slowdown_gain;
            op_mag  = rate_reg;
        end
    end

    // Subtract both slowdown terms at full width, then floor at min_speed
    always_comb
    begin
        tgt_raw = TGT_W'({1'b0, cfg.speed_setpoint})
                - TGT_W'({1'b0, slow_angle_reg})
                - TGT_W'({1'b0, prod_reg[SLOW_PROD_W-1:Q_FRAC_W]});
        if (tgt_raw < $signed(TGT_W'({1'b0, cfg.min_speed})))
            target_next = cfg.min_speed;
        else
            target_next = tgt_raw[DATA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= (state_reg == S_TGT);
        end
    end

    // Hold the magnitudes, products and target
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            angle_reg <= angle;
            rate_reg  <= rate;
        end
        prod_reg <= op_gain * op_mag;
        if (state_reg == S_RATE)
            slow_angle_reg <= prod_reg[SLOW_PROD_W-1:Q_FRAC_W];
        if (state_reg == S_TGT)
            target_reg <= target_next;
    end

    assign target_valid = valid_reg;
    assign target       = target_reg;

endmodule

### rtl/core/dwsp_lane.sv
`include "dual_wheel_speed_pid_unit_macros.svh"

module dwsp_lane (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dwsp_pkg::cfg_t                cfg,
    input  logic                          start,
    input  logic [dwsp_pkg::DATA_W-1:0]   target,
    input  logic [dwsp_pkg::DATA_W-1:0]   count,
    input  logic                          take,
    output dwsp_pkg::lane_stat_t          stat
);
    import dwsp_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_MEAS  = 10'b00_0000_0010,
        S_ERR   = 10'b00_0000_0100,
        S_PTERM = 10'b00_0000_1000,
        S_DTERM = 10'b00_0001_0000,
        S_ITERM = 10'b00_0010_0000,
        S_SUM   = 10'b00_0100_0000,
        S_SCALE = 10'b00_1000_0000,
        S_DONE  = 10'b01_0000_0000,
        S_HOLD  = 10'b10_0000_0000
    } lane_state_e;

    lane_state_e                state_reg, state_next;
    logic [DATA_W-1:0]          target_reg, count_reg;
    logic signed [MUL_A_W-1:0]  op_a;
    logic signed [MUL_B_W-1:0]  op_b;
    logic signed [PROD_W-1:0]   mul_reg;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [ERR_W-1:0]    err_next, err_reg, last_err_reg;
    logic signed [ERR_W:0]      deriv_reg;
    logic signed [INTEG_W:0]    integ_sum;
    logic signed [INTEG_W-1:0]  integ_next, integ_reg;
    logic                       windup, windup_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [SCL_W-1:0]    acc_ext, scaled, scaled_reg;
    logic [WHOLE_W-1:0]         whole;
    logic [DUTY_W-1:0]          duty_next, last_duty_reg;
    logic                       brake_next;
    lane_res_t                  res_reg;
    logic                       res_valid_reg;

    // Step through the products on one shared multiplier
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start) state_next = S_MEAS;
            S_MEAS:  state_next = S_ERR;
            S_ERR:   state_next = S_PTERM;
            S_PTERM: state_next = S_DTERM;
            S_DTERM: state_next = S_ITERM;
            S_ITERM: state_next = S_SUM;
            S_SUM:   state_next = S_SCALE;
            S_SCALE: state_next = S_DONE;
            S_DONE:  state_next = S_HOLD;
            S_HOLD:  if (take) state_next = S_IDLE;
        endcase
    end

    // Select multiplier operands
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            S_MEAS:
            begin
                op_a = {1'b0, cfg.speed_per_count};
                op_b = MUL_B_W'(count_reg);
            end
            S_PTERM:
            begin
                op_a = {1'b0, cfg.prop_gain};
                op_b = MUL_B_W'(err_reg);
            end
            S_DTERM:
            begin
                op_a = {1'b0, cfg.deriv_gain};
                op_b = MUL_B_W'(deriv_reg);
            end
            S_ITERM:
            begin
                op_a = {1'b0, cfg.integ_gain};
                op_b = windup_reg ? '0 : MUL_B_W'(integ_reg);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Saturate the speed error to 24 bits
    always_comb
    begin
        diff = DIFF_W'($signed({1'b0, target_reg})) - $signed(mul_reg[DIFF_W-1:0]);
        if (diff[DIFF_W-1:ERR_W-1] == '0 || diff[DIFF_W-1:ERR_W-1] == '1)
            err_next = diff[ERR_W-1:0];
        else if (diff[DIFF_W-1])
            err_next = ERR_MIN_V;
        else
            err_next = ERR_MAX_V;
    end

    // Clear the integral at a rail when the error pushes further, else saturate
    always_comb
    begin
        windup = (last_duty_reg == DUTY_MAX && !err_reg[ERR_W-1] && (|err_reg))
              || (last_duty_reg == '0 && err_reg[ERR_W-1]);
        integ_sum = (INTEG_W+1)'(integ_reg) + (INTEG_W+1)'(err_reg);
        if (integ_sum[INTEG_W] == integ_sum[INTEG_W-1])
            integ_next = integ_sum[INTEG_W-1:0];
        else if (integ_sum[INTEG_W])
            integ_next = INTEG_MIN_V;
        else
            integ_next = INTEG_MAX_V;
    end

    // Scale by 100 as a shift-add
    always_comb
    begin
        acc_ext = SCL_W'(acc_reg);
        scaled  = (acc_ext <<< 6) + (acc_ext <<< 5) + (acc_ext <<< 2);
    end

    // Truncate toward zero and clamp to the duty range
    always_comb
    begin
        whole = scaled_reg[SCL_W-1:PCT_SHIFT];
        if (scaled_reg[SCL_W-1])
        begin
            duty_next  = '0;
            brake_next = !((&whole) && (|scaled_reg[PCT_SHIFT-1:0]));
        end
        else if (whole > WHOLE_W'(DUTY_MAX))
        begin
            duty_next  = DUTY_MAX;
            brake_next = 1'b0;
        end
        else
        begin
            duty_next  = whole[DUTY_W-1:0];
            brake_next = 1'b0;
        end
    end

    // Control and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            last_err_reg  <= '0;
            integ_reg     <= '0;
            last_duty_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_PTERM)
            begin
                last_err_reg <= err_reg;
                integ_reg    <= windup ? '0 : integ_next;
            end
            if (state_reg == S_DONE)
            begin
                last_duty_reg <= duty_next;
                res_valid_reg <= 1'b1;
            end
            else if (state_reg == S_HOLD && take)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        mul_reg <= op_a * op_b;
        if (state_reg == S_IDLE && start)
        begin
            target_reg <= target;
            count_reg  <= count;
        end
        if (state_reg == S_ERR)
            err_reg <= err_next;
        if (state_reg == S_PTERM)
        begin
            deriv_reg  <= (ERR_W+1)'(err_reg) - (ERR_W+1)'(last_err_reg);
            windup_reg <= windup;
        end
        unique case (state_reg)
            S_DTERM: acc_reg <= mul_reg;
            S_ITERM: acc_reg <= acc_reg - mul_reg;
            S_SUM:   acc_reg <= acc_reg + mul_reg;
            default: acc_reg <= acc_reg;
        endcase
        if (state_reg == S_SCALE)
            scaled_reg <= scaled;
        if (state_reg == S_DONE)
        begin
            res_reg.duty  <= duty_next;
            res_reg.brake <= brake_next;
        end
    end

    assign stat.valid = res_valid_reg;
    assign stat.res   = res_reg;

    `DWSP_ASSERT_NOW(a_start_idle, clk, rst_n, start, state_reg == S_IDLE, "lane started while busy")
    `DWSP_ASSERT_NEXT(a_windup_clear, clk, rst_n, (state_reg == S_PTERM) && windup, integ_reg == '0, "integral not cleared on windup")
    `DWSP_ASSERT_NEXT(a_duty_track, clk, rst_n, state_reg == S_DONE, res_reg.duty == last_duty_reg, "last duty differs from result")
    `DWSP_ASSERT_NOW(a_brake_zero, clk, rst_n, res_valid_reg && res_reg.brake, res_reg.duty == '0, "brake with nonzero duty")

endmodule

### rtl/core/dwsp_merge.sv
module dwsp_merge (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dwsp_pkg::lane_stat_t  stat_r,
    input  dwsp_pkg::lane_stat_t  stat_l,
    output logic                  take,
    dwsp_motor_if.source          motor
);
    import dwsp_pkg::*;

    logic      out_valid_reg;
    lane_res_t right_reg, left_reg;

    // Join both lanes once the output register is free
    assign take = stat_r.valid && stat_l.valid && (!out_valid_reg || motor.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take)
            out_valid_reg <= 1'b1;
        else if (motor.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            right_reg <= stat_r.res;
            left_reg  <= stat_l.res;
        end
    end

    assign motor.valid       = out_valid_reg;
    assign motor.duty_right  = right_reg.duty;
    assign motor.brake_right = right_reg.brake;
    assign motor.duty_left   = left_reg.duty;
    assign motor.brake_left  = left_reg.brake;

endmodule

### rtl/core/dual_wheel_speed_pid_unit.sv
// An input transaction passes through the target stage and both wheel lanes to the
// motor channel; no new tick is accepted until both lanes hand over their result.
// Each wheel lane runs its PID products in sequence through one 17x33 multiplier.
// A finished result waits in the output register while the next tick is accepted.
// Reset (rst_n low, asynchronous): the configuration and control registers take
// their defaults, and each wheel's error, integral and duty history clears to zero.
`include "dual_wheel_speed_pid_unit_macros.svh"

module dual_wheel_speed_pid_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dwsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dwsp_pkg::DATA_W-1:0]     cfg_wdata,
    dwsp_tick_if.sink                       tick,
    dwsp_motor_if.source                    motor
);
    import dwsp_pkg::*;

    cfg_t              cfg_reg;
    logic              busy_reg;
    logic              tick_fire;
    logic [DATA_W-1:0] count_right_reg, count_left_reg;
    logic              slow_valid;
    logic [DATA_W-1:0] target;
    lane_stat_t        stat_r, stat_l;
    logic              take;

    assign tick_fire  = tick.valid && tick.ready;
    assign tick.ready = !busy_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_e'(cfg_index))
                CFG_SPEED_SETPOINT:      cfg_reg.speed_setpoint      <= cfg_wdata;
                CFG_MIN_SPEED:           cfg_reg.min_speed           <= cfg_wdata;
                CFG_ANGLE_SLOWDOWN_GAIN: cfg_reg.angle_slowdown_gain <= cfg_wdata;
                CFG_RATE_SLOWDOWN_GAIN:  cfg_reg.rate_slowdown_gain  <= cfg_wdata;
                CFG_SPEED_PER_COUNT:     cfg_reg.speed_per_count     <= cfg_wdata;
                CFG_PROP_GAIN:           cfg_reg.prop_gain           <= cfg_wdata;
                CFG_INTEG_GAIN:          cfg_reg.integ_gain          <= cfg_wdata;
                CFG_DERIV_GAIN:          cfg_reg.deriv_gain          <= cfg_wdata;
            endcase
        end
    end

    // Hold off new ticks until the lanes hand over their result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (tick_fire)
            busy_reg <= 1'b1;
        else if (take)
            busy_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            count_right_reg <= tick.count_right;
            count_left_reg  <= tick.count_left;
        end
    end

    dwsp_slow u_slow (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .start        (tick_fire),
        .angle        (tick.steer_angle_mag),
        .rate         (tick.steer_rate_mag),
        .target_valid (slow_valid),
        .target       (target)
    );

    dwsp_lane u_lane_right (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .start  (slow_valid),
        .target (target),
        .count  (count_right_reg),
        .take   (take),
        .stat   (stat_r)
    );

    dwsp_lane u_lane_left (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .start  (slow_valid),
        .target (target),
        .count  (count_left_reg),
        .take   (take),
        .stat   (stat_l)
    );

    dwsp_merge u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .stat_r (stat_r),
        .stat_l (stat_l),
        .take   (take),
        .motor  (motor)
    );

    `DWSP_ASSERT_NEXT(a_busy_after_tick, clk, rst_n, tick_fire, !tick.ready, "tick accepted while busy")
    `DWSP_ASSERT_NOW(a_lanes_lockstep, clk, rst_n, 1'b1, stat_r.valid == stat_l.valid, "lanes out of step")
    `DWSP_ASSERT_NOW(a_idle_quiet, clk, rst_n, !busy_reg, !slow_valid && !stat_r.valid, "work pending while idle")

endmodule

### tb/duty_cmd_scoreboard.sv
module duty_cmd_scoreboard
    import dwsp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_wdata,
    dwsp_tick_if                 tick,
    dwsp_motor_if                motor,
    output int                   fail_count,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint PCT_FULL = 100;
    localparam longint PCT_DIV  = longint'(1) << PCT_SHIFT;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_right;
        logic              brake_right;
        logic [DUTY_W-1:0] duty_left;
        logic              brake_left;
    } duty_cmd_t;

    cfg_t                      regs;
    logic signed [ERR_W-1:0]   prev_err [2];
    logic signed [INTEG_W-1:0] integ_acc [2];
    logic [DUTY_W-1:0]         prev_duty [2];
    duty_cmd_t                 expected_cmds [$];
    int                        errs = 0;
    int                        pend = 0;

    assign fail_count = errs;
    assign pending    = pend;

    // Run one wheel's target, error, PID and clamp; advance its history
    task automatic update_wheel(input int w, input logic [DATA_W-1:0] cnt,
                                input longint slow, output logic [DUTY_W-1:0] duty,
                                output logic brake);
        longint floor_v, tgt, meas, spc, e, le, kp, ki, kd, acc, isum, pct;
        longint e_hi, e_lo, i_hi, i_lo;
        logic   windup;
        e_hi    = ERR_MAX_V;
        e_lo    = ERR_MIN_V;
        i_hi    = INTEG_MAX_V;
        i_lo    = INTEG_MIN_V;
        floor_v = regs.min_speed;
        tgt     = regs.speed_setpoint;
        spc     = regs.speed_per_count;
        kp      = regs.prop_gain;
        ki      = regs.integ_gain;
        kd      = regs.deriv_gain;
        meas    = cnt;

        // Slow the target down, but never below the floor
        tgt = tgt - slow;
        if (tgt < floor_v)
            tgt = floor_v;
        meas = meas * spc;

        // Saturate the speed error to its register width
        e = tgt - meas;
        if (e > e_hi)
            e = e_hi;
        if (e < e_lo)
            e = e_lo;
        le = prev_err[w];

        // Drop the integral when the last duty sat on a rail and the error pushes further
        windup = (prev_duty[w] == DUTY_MAX && e > 0) || (prev_duty[w] == '0 && e < 0);
        acc = kp * e - kd * (e - le);
        if (windup) begin
            integ_acc[w] = '0;
        end
        else begin
            isum = integ_acc[w];
            isum = isum + e;
            if (isum > i_hi)
                isum = i_hi;
            if (isum < i_lo)
                isum = i_lo;
            integ_acc[w] = INTEG_W'(isum);
            acc = acc + ki * isum;
        end
        prev_err[w] = ERR_W'(e);

        // Scale to percent, truncate toward zero, clamp; negative means brake
        pct = acc * PCT_FULL / PCT_DIV;
        if (pct > PCT_FULL) begin
            duty  = DUTY_MAX;
            brake = 1'b0;
        end
        else if (pct < 0) begin
            duty  = '0;
            brake = 1'b1;
        end
        else begin
            duty  = DUTY_W'(pct);
            brake = 1'b0;
        end
        prev_duty[w] = duty;
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errs++;
        end
    endfunction

    // Track register writes, predict on each tick transaction, compare each motor transaction
    always @(posedge clk or negedge rst_n) begin
        duty_cmd_t cmd;
        duty_cmd_t seen;
        longint    ang, rate, ag, rg, slow;
        if (!rst_n) begin
            regs = CFG_RESET;
            for (int w = 0; w < 2; w++) begin
                prev_err[w]  = '0;
                integ_acc[w] = '0;
                prev_duty[w] = '0;
            end
            expected_cmds.delete();
            pend = 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_idx_e'(cfg_index))
                    CFG_SPEED_SETPOINT:      regs.speed_setpoint      = cfg_wdata;
                    CFG_MIN_SPEED:           regs.min_speed           = cfg_wdata;
                    CFG_ANGLE_SLOWDOWN_GAIN: regs.angle_slowdown_gain = cfg_wdata;
                    CFG_RATE_SLOWDOWN_GAIN:  regs.rate_slowdown_gain  = cfg_wdata;
                    CFG_SPEED_PER_COUNT:     regs.speed_per_count     = cfg_wdata;
                    CFG_PROP_GAIN:           regs.prop_gain           = cfg_wdata;
                    CFG_INTEG_GAIN:          regs.integ_gain          = cfg_wdata;
                    CFG_DERIV_GAIN:          regs.deriv_gain          = cfg_wdata;
                    default: ;
                endcase
            end

            if (tick.valid && tick.ready) begin
                ang  = tick.steer_angle_mag;
                rate = tick.steer_rate_mag;
                ag   = regs.angle_slowdown_gain;
                rg   = regs.rate_slowdown_gain;
                slow = ((ag * ang) >> Q_FRAC_W) + ((rg * rate) >> Q_FRAC_W);
                update_wheel(0, tick.count_right, slow, cmd.duty_right, cmd.brake_right);
                update_wheel(1, tick.count_left, slow, cmd.duty_left, cmd.brake_left);
                expected_cmds.push_back(cmd);
            end

            if (motor.valid && motor.ready) begin
                seen.duty_right  = motor.duty_right;
                seen.brake_right = motor.brake_right;
                seen.duty_left   = motor.duty_left;
                seen.brake_left  = motor.brake_left;
                if (expected_cmds.size() == 0) begin
                    $error("motor transaction with nothing expected: duty_right=%0d brake_right=%0d duty_left=%0d brake_left=%0d",
                           seen.duty_right, seen.brake_right, seen.duty_left, seen.brake_left);
                    errs++;
                end
                else begin
                    cmd = expected_cmds.pop_front();
                    check_field("duty_right", cmd.duty_right, seen.duty_right);
                    check_field("brake_right", cmd.brake_right, seen.brake_right);
                    check_field("duty_left", cmd.duty_left, seen.duty_left);
                    check_field("brake_left", cmd.brake_left, seen.brake_left);
                end
            end
            pend = expected_cmds.size();
        end
    end

endmodule

### tb/dual_wheel_speed_pid_unit_tb.sv
module dual_wheel_speed_pid_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dwsp_pkg::*;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_e;

    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 135;
    localparam int ALL_ZERO_PHASE = 2;
    localparam int ALL_ONES_PHASE = 5;
    localparam int DRAIN_CYCLES   = 30;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    cfg_idx_e          cfg_index;
    logic [DATA_W-1:0] cfg_wdata;
    int                idle_pct;
    int                stall_pct;
    int                fail_count;
    int                pending;

    dwsp_tick_if  tick ();
    dwsp_motor_if motor ();

    dual_wheel_speed_pid_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .tick      (tick),
        .motor     (motor)
    );

    duty_cmd_scoreboard duty_sb (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .tick       (tick),
        .motor      (motor),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Stall the motor channel at random, per the current idling mode
    initial
    begin
        motor.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            motor.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic set_idling(input idle_mode_e mode);
        case (mode)
            IDLE_NONE:     begin idle_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin idle_pct = 74; stall_pct = 0;  end
            IDLE_RECEIVER: begin idle_pct = 0;  stall_pct = 74; end
            IDLE_BOTH:     begin idle_pct = 22; stall_pct = 22; end
            default:       begin idle_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    task automatic write_reg(input cfg_idx_e idx, input logic [DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    // Write every register, then drop the write enable
    task automatic apply_settings(input cfg_t s);
        write_reg(CFG_SPEED_SETPOINT, s.speed_setpoint);
        write_reg(CFG_MIN_SPEED, s.min_speed);
        write_reg(CFG_ANGLE_SLOWDOWN_GAIN, s.angle_slowdown_gain);
        write_reg(CFG_RATE_SLOWDOWN_GAIN, s.rate_slowdown_gain);
        write_reg(CFG_SPEED_PER_COUNT, s.speed_per_count);
        write_reg(CFG_PROP_GAIN, s.prop_gain);
        write_reg(CFG_INTEG_GAIN, s.integ_gain);
        write_reg(CFG_DERIV_GAIN, s.deriv_gain);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one tick transaction, with an optional random gap first; return once accepted
    task automatic send_tick(input logic [DATA_W-1:0] cr, input logic [DATA_W-1:0] cl,
                             input logic [DATA_W-1:0] ang, input logic [DATA_W-1:0] rate);
        logic taken;
        if ($urandom_range(99) < idle_pct) begin
            tick.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        tick.valid           <= 1'b1;
        tick.count_right     <= cr;
        tick.count_left      <= cl;
        tick.steer_angle_mag <= ang;
        tick.steer_rate_mag  <= rate;
        do
        begin
            @(negedge clk);
            taken = tick.ready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    // Hold the sender until every predicted command has come back
    task automatic finish_burst();
        tick.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    function automatic logic [DATA_W-1:0] knob(input int hi);
        if ($urandom_range(7) == 0)
            return DATA_W'($urandom);
        return DATA_W'($urandom_range(hi));
    endfunction

    function automatic cfg_t random_settings();
        cfg_t s;
        s.speed_setpoint      = knob(4095);
        s.min_speed           = knob(1023);
        s.angle_slowdown_gain = knob(255);
        s.rate_slowdown_gain  = knob(255);
        s.speed_per_count     = knob(32);
        s.prop_gain           = knob(64);
        s.integ_gain          = knob(8);
        s.deriv_gain          = knob(64);
        return s;
    endfunction

    // Half the time a count near the setpoint speed, so the loop stays off its rails
    function automatic logic [DATA_W-1:0] pick_count(input int nominal);
        int v;
        case ($urandom_range(7))
            0, 1, 2, 3: begin
                v = nominal + int'($urandom_range(128)) - 64;
                if (v < 0)
                    v = 0;
                if (v > 65535)
                    v = 65535;
                return DATA_W'(v);
            end
            4:       return DATA_W'($urandom_range(255));
            5:       return DATA_W'($urandom_range(65535));
            6:       return $urandom_range(1) ? {DATA_W{1'b1}} : '0;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_mag();
        case ($urandom_range(7))
            0, 1, 2, 3: return DATA_W'($urandom_range(1023));
            4:          return '0;
            5:          return {DATA_W{1'b1}};
            default:    return DATA_W'($urandom);
        endcase
    endfunction

    initial
    begin : stimulus
        cfg_t mild;
        cfg_t hard;
        cfg_t s;
        int   nominal;

        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_SPEED_SETPOINT;
        cfg_wdata            = '0;
        tick.valid           = 1'b0;
        tick.count_right     = '0;
        tick.count_left      = '0;
        tick.steer_angle_mag = '0;
        tick.steer_rate_mag  = '0;
        set_idling(IDLE_NONE);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults straight out of reset
        send_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_tick(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        finish_burst();

        // Moderate gains: zero error, floored target, both slowdowns, field extremes
        mild = '{speed_setpoint: 16'd1536, min_speed: 16'd384, angle_slowdown_gain: 16'd64,
                 rate_slowdown_gain: 16'd32, speed_per_count: 16'd8, prop_gain: 16'd20,
                 integ_gain: 16'd2, deriv_gain: 16'd10};
        apply_settings(mild);
        send_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_tick(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_tick(16'd192, 16'd192, 16'h0000, 16'h0000);
        send_tick(16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
        send_tick(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
        send_tick(16'd100, 16'd100, 16'hFFFF, 16'h0000);
        send_tick(16'd100, 16'd100, 16'h0000, 16'hFFFF);
        send_tick(16'd100, 16'd100, 16'h0100, 16'h0100);
        send_tick(16'h8000, 16'h0001, 16'h00FF, 16'hFF00);
        send_tick(16'h0001, 16'h0002, 16'h5555, 16'hAAAA);
        finish_burst();

        // Hard gains: drive both rails, hold there for windup, saturate the error low
        hard = '{speed_setpoint: 16'hFFFF, min_speed: 16'h0000, angle_slowdown_gain: 16'hFFFF,
                 rate_slowdown_gain: 16'h0000, speed_per_count: 16'hFFFF, prop_gain: 16'hFFFF,
                 integ_gain: 16'hFFFF, deriv_gain: 16'h0000};
        apply_settings(hard);
        send_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_tick(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
        send_tick(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
        send_tick(16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
        send_tick(16'h0001, 16'h0000, 16'h0000, 16'h0000);
        send_tick(16'h0000, 16'h0001, 16'h0000, 16'h0000);
        send_tick(16'h0002, 16'h0002, 16'h0000, 16'h0000);
        finish_burst();

        // Random phases: rotate idling modes and settings, pause once midway
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == ALL_ZERO_PHASE)
                s = '0;
            else if (p == ALL_ONES_PHASE)
                s = '1;
            else
                s = random_settings();
            apply_settings(s);
            set_idling(idle_mode_e'(p % 4));
            nominal = (s.speed_per_count == 0) ? 0 : s.speed_setpoint / s.speed_per_count;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2)
                    finish_burst();
                send_tick(pick_count(nominal), pick_count(nominal), pick_mag(), pick_mag());
            end
            finish_burst();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Bound the run
    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
